### rtl/humidity_temp_frame_checker_top_assert.svh
// Assertion macros shared by the frame checker modules.
// Needs a signal named clock and an active-high reset named reset in scope.
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_TOP_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTFC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame checker assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HTFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame checker assertion failed");

`endif

### rtl/htfc_pkg.sv
// Shared types, constants and functions of the humidity/temperature frame checker.
// Depends on nothing; used by all RTL modules of the block.
package htfc_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [2:0] COUNT_MAX = 3'd7;
   localparam logic [2:0] FRAME_LEN = 3'd6;

   // Byte positions within a readout frame.
   localparam logic [2:0] POS_TEMP_HI  = 3'd0;
   localparam logic [2:0] POS_TEMP_LO  = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_HI   = 3'd3;
   localparam logic [2:0] POS_HUM_LO   = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   // Conversion scales and offsets; every product stays below 2**31.
   localparam logic [30:0] SCALE_C  = 31'd17500;
   localparam logic [30:0] SCALE_F  = 31'd31500;
   localparam logic [29:0] SCALE_H  = 30'd10000;
   localparam logic [14:0] OFFSET_C = 15'd4500;
   localparam logic [15:0] OFFSET_F = 16'd4900;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_LENGTH   = 2'd1,
      ERR_TEMP_CRC = 2'd2,
      ERR_HUM_CRC  = 2'd3
   } err_kind_type;

   typedef struct packed {
      logic [15:0]  raw_temperature;
      logic [15:0]  raw_humidity;
      err_kind_type error_kind;
   } frame_rec_type;

   typedef struct packed {
      logic [15:0]        raw_temperature;
      logic [15:0]        raw_humidity;
      logic               frame_error;
      err_kind_type       error_kind;
      logic signed [14:0] temp_centi_c;
      logic signed [15:0] temp_centi_f;
      logic [13:0]        humidity_fraction;
   } result_type;

   // One byte through the CRC-8 register, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(n / 65535) for n below 2**31. With n = a*2**16 + b we have
   // n = a*65535 + (a + b), and a + b stays below twice 65535.
   function automatic logic [15:0] div_full_scale(input logic [30:0] n);
      logic [14:0] a;
      logic [15:0] b;
      logic [16:0] s;
      a = n[30:16];
      b = n[15:0];
      s = {2'b00, a} + {1'b0, b};
      return {1'b0, a} + ((s >= 17'd65535) ? 16'd1 : 16'd0);
   endfunction

endpackage

### rtl/humidity_temp_frame_checker_top.sv
// Top level of the humidity/temperature readout frame checker.
// Depends on htfc_pkg, htfc_frame and htfc_convert.
//
// Takes one frame byte per word on the req channel, every cycle if offered while req_tready is high, and
// gives one result word on the rsp channel for each byte marked tlast. A frame is
// temperature word, its CRC-8 (polynomial 0x31, start 0xFF), humidity word, its
// CRC-8; any other length or a bad CRC is flagged in tuser and zeroes the raw words.
// After the edge that takes the last byte, the frame record register, the conversion
// product register and the result register load in that order; rsp_tvalid rises with the
// result register, and back-pressure on the rsp side can hold a frame in any of them.
// The rsp side has its own output register, so bytes keep flowing while a result
// waits; req_tready only falls when all three registers hold unclaimed data.
module humidity_temp_frame_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // byte_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [15:0] raw_temperature, [31:16] raw_humidity,
                                    // [46:32] temp_centi_c, [62:47] temp_centi_f,
                                    // [76:63] humidity_fraction, [79:77] zero
   output logic [2:0]  rsp_tuser    // [0] frame_error, [2:1] error_kind
);

   logic                    rec_valid;
   logic                    rec_ready;
   htfc_pkg::frame_rec_type rec;
   htfc_pkg::result_type    result;

   htfc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata),
      .byte_last  (req_tlast),
      .rec_valid  (rec_valid),
      .rec_ready  (rec_ready),
      .rec        (rec)
   );

   htfc_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_valid),
      .rec_ready  (rec_ready),
      .rec        (rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {3'b000,
                       result.humidity_fraction,
                       result.temp_centi_f,
                       result.temp_centi_c,
                       result.raw_humidity,
                       result.raw_temperature};
   assign rsp_tuser = {result.error_kind, result.frame_error};

endmodule

### rtl/htfc_frame.sv
// Frame assembler: running CRC, byte count and word capture, and the frame record register.
// Depends on htfc_pkg and the assertion macro header.
`include "humidity_temp_frame_checker_top_assert.svh"

module htfc_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             rx_byte,
   input  logic                   byte_last,
   output logic                   rec_valid,
   input  logic                   rec_ready,
   output htfc_pkg::frame_rec_type rec
);

   logic [2:0]  count_ff, count_in, count_upd;
   logic [7:0]  crc_ff, crc_in, crc_upd;
   logic [15:0] tword_ff, tword_in, tword_upd;
   logic [15:0] hword_ff, hword_in, hword_upd;
   logic        tok_ff, tok_in, tok_upd;
   logic        hok_ff, hok_in, hok_upd;
   logic        rec_valid_ff, rec_valid_in;
   htfc_pkg::frame_rec_type rec_ff, rec_in;
   htfc_pkg::err_kind_type  kind;
   logic        accept;
   logic        accept_last;

   assign req_tready  = !rec_valid_ff || rec_ready;
   assign accept      = req_tvalid && req_tready;
   assign accept_last = accept && byte_last;

   always_comb begin
      tword_upd = tword_ff;
      hword_upd = hword_ff;
      tok_upd   = tok_ff;
      hok_upd   = hok_ff;
      crc_upd   = crc_ff;
      unique case (count_ff)
         htfc_pkg::POS_TEMP_HI: begin
            tword_upd = {rx_byte, 8'h00};
            crc_upd   = htfc_pkg::crc8_byte(crc_ff, rx_byte);
         end
         htfc_pkg::POS_TEMP_LO: begin
            tword_upd = {tword_ff[15:8], rx_byte};
            crc_upd   = htfc_pkg::crc8_byte(crc_ff, rx_byte);
         end
         htfc_pkg::POS_TEMP_CRC: begin
            tok_upd = (crc_ff == rx_byte);
            crc_upd = htfc_pkg::CRC_INIT;
         end
         htfc_pkg::POS_HUM_HI: begin
            hword_upd = {rx_byte, 8'h00};
            crc_upd   = htfc_pkg::crc8_byte(crc_ff, rx_byte);
         end
         htfc_pkg::POS_HUM_LO: begin
            hword_upd = {hword_ff[15:8], rx_byte};
            crc_upd   = htfc_pkg::crc8_byte(crc_ff, rx_byte);
         end
         htfc_pkg::POS_HUM_CRC: begin
            hok_upd = (crc_ff == rx_byte);
            crc_upd = htfc_pkg::CRC_INIT;
         end
         default: begin
            // Bytes past the sixth are only counted.
         end
      endcase
      count_upd = (count_ff < htfc_pkg::COUNT_MAX) ? count_ff + 3'd1 : count_ff;

      priority if (count_upd != htfc_pkg::FRAME_LEN) begin
         kind = htfc_pkg::ERR_LENGTH;
      end else if (!tok_upd) begin
         kind = htfc_pkg::ERR_TEMP_CRC;
      end else if (!hok_upd) begin
         kind = htfc_pkg::ERR_HUM_CRC;
      end else begin
         kind = htfc_pkg::ERR_NONE;
      end

      rec_in.error_kind      = kind;
      rec_in.raw_temperature = (kind == htfc_pkg::ERR_NONE) ? tword_upd : 16'd0;
      rec_in.raw_humidity    = (kind == htfc_pkg::ERR_NONE) ? hword_upd : 16'd0;

      count_in = count_ff;
      crc_in   = crc_ff;
      tword_in = tword_ff;
      hword_in = hword_ff;
      tok_in   = tok_ff;
      hok_in   = hok_ff;
      if (accept_last) begin
         count_in = 3'd0;
         crc_in   = htfc_pkg::CRC_INIT;
         tword_in = 16'd0;
         hword_in = 16'd0;
         tok_in   = 1'b0;
         hok_in   = 1'b0;
      end else if (accept) begin
         count_in = count_upd;
         crc_in   = crc_upd;
         tword_in = tword_upd;
         hword_in = hword_upd;
         tok_in   = tok_upd;
         hok_in   = hok_upd;
      end

      rec_valid_in = accept_last || (rec_valid_ff && !rec_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 3'd0;
         crc_ff       <= htfc_pkg::CRC_INIT;
         tword_ff     <= 16'd0;
         hword_ff     <= 16'd0;
         tok_ff       <= 1'b0;
         hok_ff       <= 1'b0;
         rec_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         tword_ff     <= tword_in;
         hword_ff     <= hword_in;
         tok_ff       <= tok_in;
         hok_ff       <= hok_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_last) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

   `HTFC_ASSERT_NEXT(a_clear_after_last, accept_last,
                     count_ff == 3'd0 && crc_ff == htfc_pkg::CRC_INIT)
   `HTFC_ASSERT_SAME(a_good_needs_six, accept_last && kind == htfc_pkg::ERR_NONE,
                     count_ff == htfc_pkg::POS_HUM_CRC)
   `HTFC_ASSERT_NEXT(a_rec_held, rec_valid_ff && !rec_ready,
                     rec_valid_ff && $stable(rec_ff))
   `HTFC_ASSERT_SAME(a_error_zeroes_words,
                     rec_valid_ff && rec_ff.error_kind != htfc_pkg::ERR_NONE,
                     rec_ff.raw_temperature == 16'd0 && rec_ff.raw_humidity == 16'd0)

endmodule

### rtl/htfc_convert.sv
// Fixed-point conversion: product register, then division by full scale into the result register.
// Depends on htfc_pkg and the assertion macro header.
`include "humidity_temp_frame_checker_top_assert.svh"

module htfc_convert (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rec_valid,
   output logic                    rec_ready,
   input  htfc_pkg::frame_rec_type rec,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output htfc_pkg::result_type    result
);

   logic                    prod_valid_ff, prod_valid_in;
   htfc_pkg::frame_rec_type prod_rec_ff;
   logic [30:0]             prod_c_ff, prod_f_ff;
   logic [29:0]             prod_h_ff;
   logic                    out_valid_ff, out_valid_in;
   htfc_pkg::result_type    out_ff, out_in;
   logic                    out_load;
   logic                    prod_load;
   logic [15:0]             q_c, q_f, q_h;

   assign out_load  = prod_valid_ff && (!out_valid_ff || rsp_tready);
   assign rec_ready = !prod_valid_ff || out_load;
   assign prod_load = rec_valid && rec_ready;

   assign prod_valid_in = prod_load || (prod_valid_ff && !out_load);
   assign out_valid_in  = out_load || (out_valid_ff && !rsp_tready);

   always_comb begin
      q_c = htfc_pkg::div_full_scale(prod_c_ff);
      q_f = htfc_pkg::div_full_scale(prod_f_ff);
      q_h = htfc_pkg::div_full_scale({1'b0, prod_h_ff});
      out_in.raw_temperature   = prod_rec_ff.raw_temperature;
      out_in.raw_humidity      = prod_rec_ff.raw_humidity;
      out_in.frame_error       = (prod_rec_ff.error_kind != htfc_pkg::ERR_NONE);
      out_in.error_kind        = prod_rec_ff.error_kind;
      out_in.temp_centi_c      = signed'(q_c[14:0] - htfc_pkg::OFFSET_C);
      out_in.temp_centi_f      = signed'(q_f - htfc_pkg::OFFSET_F);
      out_in.humidity_fraction = q_h[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_rec_ff <= rec;
         prod_c_ff   <= 31'(rec.raw_temperature) * htfc_pkg::SCALE_C;
         prod_f_ff   <= 31'(rec.raw_temperature) * htfc_pkg::SCALE_F;
         prod_h_ff   <= 30'(rec.raw_humidity) * htfc_pkg::SCALE_H;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign result     = out_ff;

   `HTFC_ASSERT_NEXT(a_out_held, out_valid_ff && !rsp_tready,
                     out_valid_ff && $stable(out_ff))
   `HTFC_ASSERT_NEXT(a_prod_kept, prod_valid_ff && !out_load, prod_valid_ff)
   `HTFC_ASSERT_SAME(a_error_floor, out_valid_ff && out_ff.frame_error,
                     out_ff.temp_centi_c == -15'sd4500 &&
                     out_ff.humidity_fraction == 14'd0)

endmodule

### tb/htfc_frame_result_checker.sv
// Scoreboard for the humidity/temperature frame checker: predicts each result word
// from the bytes taken on the req channel and compares it with the rsp channel.
// Depends on htfc_pkg for the result layout, error kinds, byte positions and CRC constants.
module htfc_frame_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          checked_count
);

   localparam int FULL_SCALE    = 65535;
   localparam int CELSIUS_SPAN  = 17500;
   localparam int CELSIUS_BASE  = 4500;
   localparam int FAHR_SPAN     = 31500;
   localparam int FAHR_BASE     = 4900;
   localparam int HUMIDITY_SPAN = 10000;

   htfc_pkg::result_type expected_results[$];

   logic [2:0]  frame_bytes;
   logic [7:0]  word_crc;
   logic [15:0] temp_word;
   logic [15:0] hum_word;
   logic        temp_crc_good;
   logic        hum_crc_good;
   int          mismatches = 0;
   int          results_seen = 0;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ htfc_pkg::CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   task automatic clear_frame();
      frame_bytes   = '0;
      word_crc      = htfc_pkg::CRC_INIT;
      temp_word     = '0;
      hum_word      = '0;
      temp_crc_good = 1'b0;
      hum_crc_good  = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic last);
      htfc_pkg::err_kind_type kind;
      htfc_pkg::result_type   r;
      int           rt;
      int           rh;
      int           tc;
      int           tf;
      int           hf;
      case (frame_bytes)
         htfc_pkg::POS_TEMP_HI: begin
            temp_word = {b, 8'h00};
            word_crc  = crc8_step(word_crc, b);
         end
         htfc_pkg::POS_TEMP_LO: begin
            temp_word[7:0] = b;
            word_crc       = crc8_step(word_crc, b);
         end
         htfc_pkg::POS_TEMP_CRC: begin
            temp_crc_good = (word_crc == b);
            word_crc      = htfc_pkg::CRC_INIT;
         end
         htfc_pkg::POS_HUM_HI: begin
            hum_word = {b, 8'h00};
            word_crc = crc8_step(word_crc, b);
         end
         htfc_pkg::POS_HUM_LO: begin
            hum_word[7:0] = b;
            word_crc      = crc8_step(word_crc, b);
         end
         htfc_pkg::POS_HUM_CRC: begin
            hum_crc_good = (word_crc == b);
            word_crc     = htfc_pkg::CRC_INIT;
         end
         default: begin
         end
      endcase
      if (frame_bytes != htfc_pkg::COUNT_MAX) frame_bytes = frame_bytes + 3'd1;
      if (last) begin
         // Length is judged first, then the temperature CRC, then the humidity CRC.
         if (frame_bytes != htfc_pkg::FRAME_LEN) kind = htfc_pkg::ERR_LENGTH;
         else if (!temp_crc_good) kind = htfc_pkg::ERR_TEMP_CRC;
         else if (!hum_crc_good) kind = htfc_pkg::ERR_HUM_CRC;
         else kind = htfc_pkg::ERR_NONE;
         rt = (kind == htfc_pkg::ERR_NONE) ? int'(temp_word) : 0;
         rh = (kind == htfc_pkg::ERR_NONE) ? int'(hum_word) : 0;
         tc = (CELSIUS_SPAN * rt) / FULL_SCALE - CELSIUS_BASE;
         tf = (FAHR_SPAN * rt) / FULL_SCALE - FAHR_BASE;
         hf = (HUMIDITY_SPAN * rh) / FULL_SCALE;
         r.raw_temperature   = rt[15:0];
         r.raw_humidity      = rh[15:0];
         r.frame_error       = (kind != htfc_pkg::ERR_NONE);
         r.error_kind        = kind;
         r.temp_centi_c      = tc[14:0];
         r.temp_centi_f      = tf[15:0];
         r.humidity_fraction = hf[13:0];
         expected_results.push_back(r);
         clear_frame();
      end
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                     name, results_seen, want, got);
         end
      end
   endtask

   task automatic check_result();
      htfc_pkg::result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Unexpected result word: tdata %h, tuser %h", rsp_tdata, rsp_tuser);
         end
      end else begin
         want = expected_results.pop_front();
         compare_field("raw_temperature", want.raw_temperature, rsp_tdata[15:0]);
         compare_field("raw_humidity", want.raw_humidity, rsp_tdata[31:16]);
         compare_field("temp_centi_c", longint'(want.temp_centi_c),
                       longint'($signed(rsp_tdata[46:32])));
         compare_field("temp_centi_f", longint'(want.temp_centi_f),
                       longint'($signed(rsp_tdata[62:47])));
         compare_field("humidity_fraction", want.humidity_fraction, rsp_tdata[76:63]);
         compare_field("tdata padding", 0, rsp_tdata[79:77]);
         compare_field("frame_error", want.frame_error, rsp_tuser[0]);
         compare_field("error_kind", want.error_kind, rsp_tuser[2:1]);
         results_seen++;
      end
   endtask

   // The result is compared before the byte of the same edge is predicted; a result
   // can never belong to a byte taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         clear_frame();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
      end
      fail_count    <= mismatches;
      pending       <= expected_results.size();
      checked_count <= results_seen;
   end

endmodule

### tb/tb_humidity_temp_frame_checker_top.sv
// Top of the frame checker testbench: clock, reset, frame stimulus, rsp back-pressure
// and the verdict. Depends on htfc_pkg, the block and htfc_frame_result_checker.
module tb_humidity_temp_frame_checker_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int fail_count;
   int pending;
   int checked_count;
   int bytes_sent = 0;
   int frames_sent = 0;
   int short_frames = 0;
   int long_frames = 0;
   int crc_broken = 0;
   int rsp_hold = 0;
   bit idle_on = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   humidity_temp_frame_checker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   htfc_frame_result_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Bit-serial CRC-8 of a whole word, MSB first, to build well-formed frames.
   function automatic logic [7:0] crc_of_word(input logic [15:0] w);
      logic [7:0] c;
      c = htfc_pkg::CRC_INIT;
      for (int n = 15; n >= 0; n--) begin
         c = (c[7] ^ w[n]) ? ({c[6:0], 1'b0} ^ htfc_pkg::CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_hold   <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // A frame is cut short or padded with random bytes when len is not six.
   task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                             input logic [7:0] tflip, input logic [7:0] hflip, input int len);
      logic [7:0] fb [12];
      fb[0] = tw[15:8];
      fb[1] = tw[7:0];
      fb[2] = crc_of_word(tw) ^ tflip;
      fb[3] = hw[15:8];
      fb[4] = hw[7:0];
      fb[5] = crc_of_word(hw) ^ hflip;
      for (int k = 6; k < 12; k++) fb[k] = 8'($urandom);
      for (int k = 0; k < len; k++) send_byte(fb[k], k == len - 1);
      frames_sent++;
      if (len < 6) short_frames++;
      else if (len > 6) long_frames++;
      else if ((tflip | hflip) != 8'h00) crc_broken++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int         r;
      int         len;
      logic [7:0] tflip;
      logic [7:0] hflip;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Word extremes, a one-byte frame, both CRCs bad, and a bad humidity CRC alone.
      send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 6);
      send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 6);
      send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1);
      send_frame(16'hBEEF, 16'h8000, 8'hFF, 8'h01, 6);
      send_frame(16'h7FFF, 16'h0001, 8'h00, 8'h80, 6);
      wait_for_results();

      while (bytes_sent < 825) begin
         if (frames_sent % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (frames_sent % 60 == 30) wait_for_results();
         r     = $urandom_range(0, 99);
         len   = 6;
         tflip = 8'h00;
         hflip = 8'h00;
         if (r >= 70 && r < 80) begin
            case ($urandom_range(1, 3))
               1: tflip = 8'($urandom_range(1, 255));
               2: hflip = 8'($urandom_range(1, 255));
               default: begin
                  tflip = 8'($urandom_range(1, 255));
                  hflip = 8'($urandom_range(1, 255));
               end
            endcase
         end else if (r >= 80 && r < 90) begin
            len = $urandom_range(1, 5);
         end else if (r >= 90) begin
            len = $urandom_range(7, 12);
            if ($urandom_range(0, 1) == 1) tflip = 8'($urandom);
         end
         send_frame(pick_word(), pick_word(), tflip, hflip, len);
      end

      wait_for_results();
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d frames: %0d short, %0d long, %0d with a corrupted CRC.",
               bytes_sent, frames_sent, short_frames, long_frames, crc_broken);
      $display("Checked %0d result words against the prediction, %0d mismatches.",
               checked_count, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d results still outstanding.", pending);
      $display("TEST FAILED");
      $finish;
   end

endmodule
